// File: rtl/bfpes_pkg.sv
package bfpes_pkg;

   localparam int STORE_BITS_DEF      = 65536;
   localparam int MAX_FIELD_WIDTH_DEF = 64;

   localparam int VALUE_W  = 64;
   localparam int WIDTH_W  = 7;
   localparam int START_W  = 16;
   localparam int COUNT_W  = 17;
   localparam int SECLEN_W = 14;
   localparam int OFF_W    = 6;
   localparam int WORD_W   = 64;

   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 104;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_MISSING = 2'd1,
      OP_READ    = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   // transaction held between the address stage and the merge stage
   typedef struct packed {
      op_type               op;
      logic [VALUE_W-1:0]   value;
      logic [WIDTH_W-1:0]   width;
      logic [OFF_W-1:0]     off;
      logic                 odd;
      logic                 err;
      logic                 check;
      logic [COUNT_W-1:0]   bit_count;
      logic [SECLEN_W-1:0]  section_length;
   } item_type;

endpackage

// File: rtl/bfpes_bank.sv
module bfpes_bank #(
   parameter int DEPTH = 2,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [bfpes_pkg::WORD_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [IDX_W-1:0]              rd_addr,
   output logic [bfpes_pkg::WORD_W-1:0]  rd_data
);

   logic [bfpes_pkg::WORD_W-1:0] mem [DEPTH];
   logic [bfpes_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write-first: a read of the word being written sees the new data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bfpes_front.sv
module bfpes_front #(
   parameter int STORE_BITS      = bfpes_pkg::STORE_BITS_DEF,
   parameter int MAX_FIELD_WIDTH = bfpes_pkg::MAX_FIELD_WIDTH_DEF,
   localparam int WORD_COUNT = (STORE_BITS + 63) / 64,
   localparam int BANK_DEPTH = WORD_COUNT / 2 + 1,
   localparam int IDX_W      = $clog2(BANK_DEPTH)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bfpes_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                               take,
   output logic                               b_valid,
   output bfpes_pkg::item_type                item,
   output logic                               rd_en,
   output logic [IDX_W-1:0]                   rd_addr_even,
   output logic [IDX_W-1:0]                   rd_addr_odd,
   output logic [IDX_W-1:0]                   wr_addr_even,
   output logic [IDX_W-1:0]                   wr_addr_odd
);

   localparam int SB_W   = $clog2(STORE_BITS + 1);
   localparam int POS_W  = (SB_W > bfpes_pkg::START_W) ? SB_W : bfpes_pkg::START_W;
   localparam int WADR_W = POS_W - 6;

   bfpes_pkg::op_type                  op_in;
   logic [bfpes_pkg::VALUE_W-1:0]      value_in;
   logic [bfpes_pkg::WIDTH_W-1:0]      width_in;
   logic [bfpes_pkg::START_W-1:0]      start_in;
   logic                               check_in;
   logic                               accept;
   logic                               too_wide;
   logic [SB_W:0]                      app_sum;
   logic                               app_ovf;
   logic [POS_W:0]                     rd_sum;
   logic                               rd_beyond;
   logic                               is_app;
   logic                               err_in;
   logic [SB_W-1:0]                    stored_next;
   logic [SB_W-1:0]                    stored_in;
   logic [SB_W-1:0]                    stored_ff;
   logic [SB_W:0]                      seclen_sum;
   logic [POS_W-1:0]                   pos;
   logic [WADR_W-1:0]                  word;
   logic [WADR_W-1:0]                  half;
   logic [WADR_W-1:0]                  half_inc;
   logic                               b_valid_in;
   logic                               b_valid_ff;
   bfpes_pkg::item_type                item_in;
   bfpes_pkg::item_type                item_ff;
   logic [IDX_W-1:0]                   wr_addr_even_ff;
   logic [IDX_W-1:0]                   wr_addr_odd_ff;

   assign op_in    = bfpes_pkg::op_type'(req_tdata[1:0]);
   assign value_in = req_tdata[65:2];
   assign width_in = req_tdata[72:66];
   assign start_in = req_tdata[88:73];
   assign check_in = req_tdata[89];

   assign req_tready = !b_valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   assign too_wide  = width_in > bfpes_pkg::WIDTH_W'(MAX_FIELD_WIDTH);
   assign app_sum   = {1'b0, stored_ff} + (SB_W + 1)'(width_in);
   assign app_ovf   = app_sum > (SB_W + 1)'(STORE_BITS);
   assign rd_sum    = (POS_W + 1)'(start_in) + (POS_W + 1)'(width_in);
   assign rd_beyond = rd_sum > (POS_W + 1)'(stored_ff);
   assign is_app    = (op_in == bfpes_pkg::OP_APPEND) || (op_in == bfpes_pkg::OP_MISSING);

   always_comb begin
      err_in      = 1'b0;
      stored_next = stored_ff;
      case (op_in)
         bfpes_pkg::OP_CLEAR: begin
            stored_next = '0;
         end
         bfpes_pkg::OP_READ: begin
            err_in = too_wide || rd_beyond;
         end
         default: begin
            err_in = too_wide || app_ovf;
            if (!err_in) begin
               stored_next = app_sum[SB_W-1:0];
            end
         end
      endcase
   end

   assign stored_in  = accept ? stored_next : stored_ff;
   assign seclen_sum = (({1'b0, stored_next} + (SB_W + 1)'(7)) >> 3) + (SB_W + 1)'(4);

   // word pair covering the field: word w and w+1 sit in opposite banks
   assign pos      = is_app ? POS_W'(stored_ff) : POS_W'(start_in);
   assign word     = pos[POS_W-1:6];
   assign half     = word >> 1;
   assign half_inc = half + WADR_W'(1);

   assign rd_addr_odd  = half[IDX_W-1:0];
   assign rd_addr_even = word[0] ? half_inc[IDX_W-1:0] : half[IDX_W-1:0];
   assign rd_en        = accept && !err_in && (op_in != bfpes_pkg::OP_CLEAR) &&
                         (width_in != '0);

   always_comb begin
      item_in.op             = op_in;
      item_in.value          = value_in;
      item_in.width          = width_in;
      item_in.off            = pos[5:0];
      item_in.odd            = word[0];
      item_in.err            = err_in;
      item_in.check          = check_in;
      item_in.bit_count      = bfpes_pkg::COUNT_W'(stored_next);
      item_in.section_length = bfpes_pkg::SECLEN_W'(seclen_sum);
   end

   assign b_valid_in = accept ? 1'b1 : (take ? 1'b0 : b_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff  <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         stored_ff  <= stored_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff         <= item_in;
         wr_addr_even_ff <= rd_addr_even;
         wr_addr_odd_ff  <= rd_addr_odd;
      end
   end

   assign b_valid      = b_valid_ff;
   assign item         = item_ff;
   assign wr_addr_even = wr_addr_even_ff;
   assign wr_addr_odd  = wr_addr_odd_ff;

endmodule

// File: rtl/bfpes_merge.sv
module bfpes_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               b_valid,
   input  bfpes_pkg::item_type                item,
   input  logic [bfpes_pkg::WORD_W-1:0]       rd_even,
   input  logic [bfpes_pkg::WORD_W-1:0]       rd_odd,
   output logic                               take,
   output logic                               wr_en,
   output logic [bfpes_pkg::WORD_W-1:0]       wr_even,
   output logic [bfpes_pkg::WORD_W-1:0]       wr_odd,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bfpes_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int W  = bfpes_pkg::WORD_W;
   localparam int PW = 2 * W;

   logic [W-1:0]                       hi;
   logic [W-1:0]                       lo;
   logic [PW-1:0]                      pair;
   logic [7:0]                         sh;
   logic [W-1:0]                       fmask;
   logic [W-1:0]                       field_raw;
   logic [W-1:0]                       ins;
   logic [PW-1:0]                      pmask;
   logic [PW-1:0]                      pdata;
   logic [PW-1:0]                      merged;
   logic                               is_app;
   logic                               rd_ok;
   logic                               missing;
   logic [W-1:0]                       field;
   logic                               rsp_valid_in;
   logic                               rsp_valid_ff;
   logic [bfpes_pkg::RSP_TDATA_W-1:0]  rsp_data_in;
   logic [bfpes_pkg::RSP_TDATA_W-1:0]  rsp_data_ff;

   assign take = b_valid && (!rsp_valid_ff || rsp_tready);

   // field window: word w in the high half, word w+1 in the low half
   assign hi   = item.odd ? rd_odd : rd_even;
   assign lo   = item.odd ? rd_even : rd_odd;
   assign pair = {hi, lo};
   assign sh   = 8'd128 - {2'b00, item.off} - {1'b0, item.width};

   assign fmask     = ~({W{1'b1}} << item.width);
   assign field_raw = W'(pair >> sh) & fmask;

   assign is_app = (item.op == bfpes_pkg::OP_APPEND) || (item.op == bfpes_pkg::OP_MISSING);
   assign ins    = (item.op == bfpes_pkg::OP_MISSING) ? fmask : (item.value & fmask);
   assign pmask  = {{W{1'b0}}, fmask} << sh;
   assign pdata  = {{W{1'b0}}, ins} << sh;
   assign merged = (pair & ~pmask) | pdata;

   assign wr_even = item.odd ? merged[W-1:0] : merged[PW-1:W];
   assign wr_odd  = item.odd ? merged[PW-1:W] : merged[W-1:0];
   assign wr_en   = take && is_app && !item.err && (item.width != '0);

   assign rd_ok   = (item.op == bfpes_pkg::OP_READ) && !item.err;
   assign missing = rd_ok && item.check && (item.width > bfpes_pkg::WIDTH_W'(1)) &&
                    (field_raw == fmask);
   assign field   = missing ? {W{1'b1}} : (rd_ok ? field_raw : '0);

   assign rsp_data_in  = {7'b0, item.err, item.section_length, item.bit_count, missing, field};
   assign rsp_valid_in = take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/bit_field_pack_and_extract_store.sv
// Bit string store that appends and extracts MSB-first fields of 0 to 64 bits.
// req_* carries one command per transaction: append value, append all-ones
// marker, read a field at a start bit, or clear the store. rsp_* returns one
// result per command with the field, missing flag, bit count, section length
// and error flag.
// The banks are read as a command is accepted; the merged result is registered
// onto rsp_* as the command leaves the merge stage. Throughput: one command per
// cycle while rsp_tready stays high. The bit string lives in two 64-bit word
// banks (even and odd words); a field covers at most one word of each, so both
// are read at acceptance and written back as the command leaves the merge
// stage. A command accepted in the write-back cycle of the previous one gets
// the new word data through write-first forwarding in the bank.
// Reset empties the store (bit count zero); memory contents are not cleared
// and no clearing pass is needed.
// If rsp_tready is low the result stays in the output register; one more
// command may still be accepted into the merge stage, after which req_tready
// drops until the result is taken.
module bit_field_pack_and_extract_store #(
   parameter int STORE_BITS      = bfpes_pkg::STORE_BITS_DEF,
   parameter int MAX_FIELD_WIDTH = bfpes_pkg::MAX_FIELD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // func[1:0], value[65:2], width[72:66], start_bit[88:73], check_missing[89]
   input  logic [bfpes_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // field_value[63:0], is_missing[64], bit_count[81:65],
   // section_length[95:82], error[96]
   output logic [bfpes_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int WORD_COUNT = (STORE_BITS + 63) / 64;
   localparam int BANK_DEPTH = WORD_COUNT / 2 + 1;
   localparam int IDX_W      = $clog2(BANK_DEPTH);

   logic                           take;
   logic                           b_valid;
   bfpes_pkg::item_type            item;
   logic                           rd_en;
   logic [IDX_W-1:0]               rd_addr_even;
   logic [IDX_W-1:0]               rd_addr_odd;
   logic [IDX_W-1:0]               wr_addr_even;
   logic [IDX_W-1:0]               wr_addr_odd;
   logic                           wr_en;
   logic [bfpes_pkg::WORD_W-1:0]   wr_even;
   logic [bfpes_pkg::WORD_W-1:0]   wr_odd;
   logic [bfpes_pkg::WORD_W-1:0]   rd_even;
   logic [bfpes_pkg::WORD_W-1:0]   rd_odd;

   bfpes_front #(
      .STORE_BITS      (STORE_BITS),
      .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .take         (take),
      .b_valid      (b_valid),
      .item         (item),
      .rd_en        (rd_en),
      .rd_addr_even (rd_addr_even),
      .rd_addr_odd  (rd_addr_odd),
      .wr_addr_even (wr_addr_even),
      .wr_addr_odd  (wr_addr_odd)
   );

   bfpes_bank #(
      .DEPTH (BANK_DEPTH)
   ) u_bank_even (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_even),
      .wr_data (wr_even),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_even),
      .rd_data (rd_even)
   );

   bfpes_bank #(
      .DEPTH (BANK_DEPTH)
   ) u_bank_odd (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_odd),
      .wr_data (wr_odd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_odd),
      .rd_data (rd_odd)
   );

   bfpes_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .b_valid    (b_valid),
      .item       (item),
      .rd_even    (rd_even),
      .rd_odd     (rd_odd),
      .take       (take),
      .wr_en      (wr_en),
      .wr_even    (wr_even),
      .wr_odd     (wr_odd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a clear empties the store and is never refused
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata[1:0] == bfpes_pkg::OP_CLEAR))
      |=> (item.bit_count == '0) && !item.err)
      else $error("clear did not empty the store");

   // input backpressure only when the merge stage is full and the output stalls
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (b_valid && rsp_tvalid && !rsp_tready))
      else $error("req_tready low without a stalled result");

   // missing results carry an all-ones field and no error
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[64]) |-> ((rsp_tdata[63:0] == '1) && !rsp_tdata[96]))
      else $error("missing flag with a bad field or error");

   // refused transactions return a zero field and no missing flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[96]) |-> (rsp_tdata[64:0] == '0))
      else $error("error result with nonzero field");

endmodule
